// File: sv/lpsd_pkg.sv
// Shared types and codes for the LED panel scan driver.
package lpsd_pkg;

  // Kind of a queued command, taken from the input tuser bit.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } op_t;

  // Back-end sequencer states.
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } bk_state_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic       half;     // 1 for the bottom half of the panel
    logic [3:0] pair;     // row within its half
    logic [4:0] column;
    logic [2:0] colour;
  } cmd_t;

  // One shift slot as delivered on the output stream.
  typedef struct packed {
    logic       latch_pulse;
    logic [4:0] shift_column;
    logic [2:0] bottom_colour;
    logic [2:0] top_colour;
    logic [2:0] row_select;
  } slot_t;

endpackage

// File: sv/lpsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpsd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lpsd_fifo.sv
// Two-entry register queue used between the pipeline parts.
module lpsd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data,
  output logic [1:0]       level
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign level      = count;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push_fire} - {1'b0, pop_fire};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sv/lpsd_front.sv
// Front end: accepts input transfers, checks bounds and classifies them.
module lpsd_front #(
  parameter int COLUMNS   = 32,
  parameter int ROW_PAIRS = 8
) (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               clearing,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output lpsd_pkg::cmd_t     cmd
);

  logic [7:0] row_x;
  logic [8:0] col_x;
  logic       row_ok;
  logic       col_ok;
  logic       half;
  logic [7:0] pair_x;
  logic       drop;

  assign row_x = {4'b0, s_axis_tdata[3:0]};
  assign col_x = {4'b0, s_axis_tdata[8:4]};

  // Bounds check and split of the panel row into half and row pair.
  always_comb begin
    row_ok = (row_x < 8'(2 * ROW_PAIRS));
    col_ok = (col_x < 9'(COLUMNS));
    half   = (row_x >= 8'(ROW_PAIRS));
    pair_x = half ? (row_x - 8'(ROW_PAIRS)) : row_x;
  end

  // Build the command; writes outside the panel are taken and dropped.
  always_comb begin
    cmd.half   = half;
    cmd.pair   = pair_x[3:0];
    cmd.column = s_axis_tdata[8:4];
    cmd.colour = s_axis_tdata[11:9];
    if (s_axis_tuser) begin
      cmd.op = lpsd_pkg::OP_SCAN;
      drop   = 1'b0;
    end else begin
      cmd.op = lpsd_pkg::OP_WRITE;
      drop   = !(row_ok && col_ok);
    end
  end

  // Nothing is taken while the frame store is being cleared.
  assign s_axis_tready = !clearing && cmd_ready;
  assign cmd_valid     = s_axis_tvalid && !clearing && !drop;

endmodule

// File: sv/lpsd_back.sv
// Back end: clears the frame store, executes writes and produces shift slots.
module lpsd_back #(
  parameter int COLUMNS   = 32,
  parameter int ROW_PAIRS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  lpsd_pkg::cmd_t     cmd,
  output logic               clearing,
  output logic               slot_valid,
  input  logic               slot_ready,
  output lpsd_pkg::slot_t    slot
);

  localparam int RW    = $clog2(ROW_PAIRS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;

  lpsd_pkg::bk_state_t state;
  lpsd_pkg::bk_state_t state_next;

  logic [AW-1:0]   clr_addr;
  logic            clr_last;
  logic [RW-1:0]   scan_row;
  logic [CW-1:0]   scan_column;
  logic            scan_last;

  logic            rd_valid;
  logic [2:0]      rd_row_select;
  logic [4:0]      rd_shift_column;
  logic            rd_latch;

  logic [1:0]      out_level;
  logic            out_pop;
  logic [1:0]      pending;
  logic            issue_ok;
  logic            do_write;
  logic            do_scan;

  logic            top_we;
  logic            bot_we;
  logic [AW-1:0]   waddr;
  logic [2:0]      wdata;
  logic [AW-1:0]   raddr;
  logic [2:0]      top_rdata;
  logic [2:0]      bot_rdata;
  lpsd_pkg::slot_t out_slot;

  // Next state: one pass over every address, then normal operation.
  always_comb begin
    state_next = state;
    unique case (state)
      lpsd_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = lpsd_pkg::ST_RUN;
        end
      end
      lpsd_pkg::ST_RUN: begin
        state_next = lpsd_pkg::ST_RUN;
      end
      default: begin
        state_next = lpsd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpsd_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == lpsd_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  assign clr_last = &clr_addr;

  // A scan may issue only if its slot will find room in the output queue.
  assign out_pop  = slot_valid && slot_ready;
  assign pending  = out_level + {1'b0, rd_valid};
  assign issue_ok = (pending <= (out_pop ? 2'd2 : 2'd1));

  // Outputs of the sequencer: command pop and RAM write port.
  always_comb begin
    clearing  = 1'b0;
    cmd_ready = 1'b0;
    do_write  = 1'b0;
    do_scan   = 1'b0;
    top_we    = 1'b0;
    bot_we    = 1'b0;
    waddr     = {RW'(cmd.pair), CW'(cmd.column)};
    wdata     = cmd.colour;
    unique case (state)
      lpsd_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        top_we   = 1'b1;
        bot_we   = 1'b1;
        waddr    = clr_addr;
        wdata    = 3'd0;
      end
      lpsd_pkg::ST_RUN: begin
        cmd_ready = (cmd.op == lpsd_pkg::OP_WRITE) || issue_ok;
        do_write  = cmd_valid && (cmd.op == lpsd_pkg::OP_WRITE);
        do_scan   = cmd_valid && (cmd.op == lpsd_pkg::OP_SCAN) && issue_ok;
        top_we    = do_write && !cmd.half;
        bot_we    = do_write && cmd.half;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  // Scan position: column runs first, the row pair advances after the last column.
  assign scan_last = (scan_column == CW'(COLUMNS - 1));
  assign raddr     = {scan_row, scan_column};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row    <= '0;
      scan_column <= '0;
    end else if (do_scan) begin
      if (scan_last) begin
        scan_column <= '0;
        scan_row    <= (scan_row == RW'(ROW_PAIRS - 1)) ? '0 : scan_row + RW'(1);
      end else begin
        scan_column <= scan_column + CW'(1);
      end
    end
  end

  // Slot fields travel alongside the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= do_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (do_scan) begin
      rd_row_select   <= 3'(scan_row);
      rd_shift_column <= 5'(scan_column);
      rd_latch        <= scan_last;
    end
  end

  // Top and bottom halves live in separate RAMs read at the same address.
  lpsd_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (top_rdata)
  );

  lpsd_ram #(.WIDTH(3), .DEPTH(DEPTH)) u_bot_ram (
    .clk   (clk),
    .we    (bot_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (bot_rdata)
  );

  always_comb begin
    out_slot.latch_pulse   = rd_latch;
    out_slot.shift_column  = rd_shift_column;
    out_slot.bottom_colour = bot_rdata;
    out_slot.top_colour    = top_rdata;
    out_slot.row_select    = rd_row_select;
  end

  // Output queue decouples the scan pipeline from the downstream stall.
  lpsd_fifo #(.WIDTH($bits(lpsd_pkg::slot_t))) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (rd_valid),
    .push_ready (),
    .push_data  (out_slot),
    .pop_valid  (slot_valid),
    .pop_ready  (slot_ready),
    .pop_data   (slot),
    .level      (out_level)
  );

endmodule

// File: sv/led_panel_scan_driver.sv
// Top level of the LED panel scan driver: front end, command queue and back end.
//
//  Channel  | Side   | Payload                                               | Transfer
//  s_axis   | input  | tuser: action; tdata: row[3:0] column[8:4] colour[11:9] | tvalid & tready
//  m_axis   | output | tdata: row_sel[2:0] top[5:3] bottom[8:6] column[13:9];   | tvalid & tready
//           |        | tlast: latch pulse                                    |
//
// One input transfer per cycle is sustained while no clear pass or output stall holds it back;
// a scan slot passes the command queue, the registered RAM read and the output queue in that
// order before it is offered.
// After reset both frame RAMs are cleared one address per cycle over all
// 2**(clog2(ROW_PAIRS)+clog2(COLUMNS)) addresses (256 by default); s_axis_tready is low then.
// A stalled output fills the two-entry output queue, then the command queue, then
// drops s_axis_tready; pixel writes keep draining as long as no scan blocks them.
module led_panel_scan_driver #(
  parameter int COLUMNS   = 32,
  parameter int ROW_PAIRS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // pixel_row, pixel_column, pixel_colour, zero pad
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // row_select, top_colour, bottom_colour, shift_column, pad
  output logic        m_axis_tlast
);

  lpsd_pkg::cmd_t  front_cmd;
  lpsd_pkg::cmd_t  back_cmd;
  lpsd_pkg::slot_t slot;
  logic            front_valid;
  logic            front_ready;
  logic            back_valid;
  logic            back_ready;
  logic            clearing;
  logic [1:0]      q_level;

  lpsd_front #(.COLUMNS(COLUMNS), .ROW_PAIRS(ROW_PAIRS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing      (clearing),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  // Command queue between classification and execution.
  lpsd_fifo #(.WIDTH($bits(lpsd_pkg::cmd_t))) u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd),
    .level      (q_level)
  );

  lpsd_back #(.COLUMNS(COLUMNS), .ROW_PAIRS(ROW_PAIRS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .clearing   (clearing),
    .slot_valid (m_axis_tvalid),
    .slot_ready (m_axis_tready),
    .slot       (slot)
  );

  // Pack the shift slot onto the output stream.
  assign m_axis_tdata = {2'b00, slot.shift_column, slot.bottom_colour,
                         slot.top_colour, slot.row_select};
  assign m_axis_tlast = slot.latch_pulse;

  // No input transfer may be taken while the frame store is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("input accepted during frame store clear");

  // The command queue never reports more than two entries.
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_level != 2'd3)
    else $error("command queue level out of range");

  // The latch flag only comes with the last column of a row.
  a_latch_last_column: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[13:9] == 5'(COLUMNS - 1)))
    else $error("latch pulse on a column other than the last");

  // Nothing is delivered while the clear pass is still running.
  a_no_slot_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !m_axis_tvalid)
    else $error("shift slot delivered during frame store clear");

endmodule
